>>> rtl/core/waypoint_to_path_segments_core_defines.svh
// Assertion helpers for the path segment core.
`ifndef WAYPOINT_TO_PATH_SEGMENTS_CORE_DEFINES_SVH
`define WAYPOINT_TO_PATH_SEGMENTS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wps assertion failed");

// Next-cycle implication, checked outside reset.
`define WPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wps assertion failed");

`endif

>>> rtl/core/wps_pkg.sv
package wps_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 256;
  localparam logic [30:0] START_SPEED = 31'd655360;
  localparam logic [30:0] CURV_MAX    = 31'h7FFF_FFFF;
  localparam logic [63:0] CURV_NUM    = 64'h0000_0100_0000_0000;
  // radius at or below this saturates curvature
  localparam logic [30:0] CURV_SAT_R  = 31'd512;

  localparam logic [2:0] MODE_STRAIGHT    = 3'd0;
  localparam logic [2:0] MODE_FLY_RIGHT   = 3'd1;
  localparam logic [2:0] MODE_DRIVE_RIGHT = 3'd2;
  localparam logic [2:0] MODE_ORBIT_RIGHT = 3'd3;
  localparam logic [2:0] MODE_FLY_LEFT    = 3'd4;
  localparam logic [2:0] MODE_DRIVE_LEFT  = 3'd5;
  localparam logic [2:0] MODE_ORBIT_LEFT  = 3'd6;

  localparam logic FUNC_START    = 1'b0;
  localparam logic FUNC_WAYPOINT = 1'b1;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } itr_op_t;

  typedef struct packed {
    logic        start;
    itr_op_t     op;
    logic [63:0] a;
    logic [31:0] b;
  } itr_ctrl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } itr_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CURV_GO,
    S_CURV_WT,
    S_VEC,
    S_SQ_N,
    S_SQ_E,
    S_SQ_ADD,
    S_SQRT_GO,
    S_SQRT_WT,
    S_MUL_N,
    S_DIVN_GO,
    S_DIVN_WT,
    S_MUL_E,
    S_DIVE_GO,
    S_DIVE_WT,
    S_EMIT_A,
    S_HOLD_A,
    S_EMIT_B,
    S_HOLD_B
  } state_t;

endpackage

>>> rtl/core/waypoint_to_path_segments_core.sv
// Waypoint to path segment descriptor generator.
// Input stream: one transaction per route start (tuser = 0) or waypoint
// (tuser = 1, tlast = final waypoint of the route). Output stream: one
// descriptor per transaction, two for orbit waypoints (entry point, then the
// endless orbit point); tlast marks the last descriptor of each input.
// One item is in work at a time; in_tready is high only while idle.
// A start item goes straight to its output state. Other waypoints wait for
// the 31-step curvature division, skipped when the radius is small enough to
// saturate. Orbit waypoints add a 32-step square root and two 31-step
// divisions before the entry point, both skipped when the centre is the
// previous locus; the orbit point follows once the entry point is taken.
// All of it runs on one shared bit-serial divide / square root unit and one
// 31x31 multiplier under the sequencer below.
// A stalled receiver holds the block in its output state; the descriptor
// stays on out_tdata until taken, and no new input is accepted meanwhile.
// Reset clears the descriptor index and the previous locus to zero.
`include "waypoint_to_path_segments_core_defines.svh"
module waypoint_to_path_segments_core #(
  parameter int unsigned MAX_SEGMENTS = wps_pkg::MAX_SEGMENTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[2:0], pos_north[34:3], pos_east[66:35], pos_down[98:67],
  // turn_radius[129:99], speed[160:130], zero fill[167:161]
  input  logic [167:0] in_tdata,
  // func
  input  logic         in_tuser,
  // route_end
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // seg_index[7:0], locus_north[39:8], locus_east[71:40], locus_down[103:72],
  // seg_speed[134:104], seg_curvature[166:135], zero fill[167]
  output logic [167:0] out_tdata,
  // orbit_forever[0], table_full[1], route_done[2]
  output logic [2:0]   out_tuser,
  // last
  output logic         out_tlast
);

  localparam int IW = $clog2(MAX_SEGMENTS + 1);

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       sat32 = 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) sat32 = 32'h8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  wps_pkg::state_t state_r, state_nxt;

  logic        func_r, func_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] cn_r, cn_nxt, ce_r, ce_nxt, cd_r, cd_nxt;
  logic [30:0] rad_r, rad_nxt, spd_r, spd_nxt;
  logic        rend_r, rend_nxt;
  logic [30:0] mag_r, mag_nxt;
  logic [30:0] an_r, an_nxt, ae_r, ae_nxt;
  logic        neg_n_r, neg_n_nxt, neg_e_r, neg_e_nxt, zero_r, zero_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [30:0] qn_r, qn_nxt, qe_r, qe_nxt;
  logic [IW-1:0] next_index_r, next_index_nxt;
  logic [31:0] prev_n_r, prev_n_nxt, prev_e_r, prev_e_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [167:0] out_data_r, out_data_nxt;
  logic [2:0]   out_user_r, out_user_nxt;
  logic         out_last_r, out_last_nxt;

  wps_pkg::itr_ctrl_t itr_ctrl;
  wps_pkg::itr_stat_t itr_stat;

  wps_itr u_itr (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (itr_ctrl),
    .stat (itr_stat)
  );

  // mode decode
  logic is_right, is_left, is_orbit;
  always_comb begin
    is_right = 1'b0;
    is_left  = 1'b0;
    unique case (mode_r)
      wps_pkg::MODE_FLY_RIGHT, wps_pkg::MODE_DRIVE_RIGHT,
      wps_pkg::MODE_ORBIT_RIGHT: is_right = 1'b1;
      wps_pkg::MODE_FLY_LEFT, wps_pkg::MODE_DRIVE_LEFT,
      wps_pkg::MODE_ORBIT_LEFT:  is_left = 1'b1;
      default: ;
    endcase
    is_orbit = (mode_r == wps_pkg::MODE_ORBIT_RIGHT) ||
               (mode_r == wps_pkg::MODE_ORBIT_LEFT);
  end

  logic [31:0] curv;
  always_comb begin
    if (is_right)     curv = {1'b0, mag_r};
    else if (is_left) curv = 32'd0 - {1'b0, mag_r};
    else              curv = '0;
  end

  // approach vector from previous locus, scaled to fit 31 bits
  logic signed [32:0] dn, de;
  logic [31:0] abs_n, abs_e;
  always_comb begin
    dn = $signed({cn_r[31], cn_r}) - $signed({prev_n_r[31], prev_n_r});
    de = $signed({ce_r[31], ce_r}) - $signed({prev_e_r[31], prev_e_r});
    abs_n = dn[32] ? 32'(-dn) : dn[31:0];
    abs_e = de[32] ? 32'(-de) : de[31:0];
  end

  // shared multiplier
  logic [30:0] mul_a, mul_b;
  logic [61:0] mul_p;
  always_comb begin
    mul_a = an_r;
    mul_b = rad_r;
    case (state_r)
      wps_pkg::S_SQ_N: begin
        mul_a = an_r;
        mul_b = an_r;
      end
      wps_pkg::S_SQ_E: begin
        mul_a = ae_r;
        mul_b = ae_r;
      end
      wps_pkg::S_MUL_E: mul_a = ae_r;
      default: ;
    endcase
    mul_p = 62'(mul_a) * 62'(mul_b);
  end

  // loci
  logic signed [32:0] offn, offe;
  logic signed [33:0] cn_s, ce_s;
  logic [31:0] en, ee, on, oe;
  always_comb begin
    if (zero_r) begin
      offn = $signed({2'b00, rad_r});
      offe = '0;
    end else begin
      offn = neg_n_r ? -$signed({2'b00, qn_r}) : $signed({2'b00, qn_r});
      offe = neg_e_r ? -$signed({2'b00, qe_r}) : $signed({2'b00, qe_r});
    end
    cn_s = $signed({{2{cn_r[31]}}, cn_r});
    ce_s = $signed({{2{ce_r[31]}}, ce_r});
    en = sat32(cn_s - 34'(offn));
    ee = sat32(ce_s - 34'(offe));
    if (is_right) begin
      on = sat32(cn_s + 34'(offn));
      oe = ee;
    end else begin
      on = en;
      oe = sat32(ce_s + 34'(offe));
    end
  end

  logic [IW-1:0] idx;
  logic          full;
  always_comb begin
    idx  = ((state_r == wps_pkg::S_EMIT_B) && (func_r == wps_pkg::FUNC_START)) ?
           '0 : next_index_r;
    full = idx >= IW'(MAX_SEGMENTS);
  end

  assign in_tready = (state_r == wps_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    mode_nxt       = mode_r;
    cn_nxt         = cn_r;
    ce_nxt         = ce_r;
    cd_nxt         = cd_r;
    rad_nxt        = rad_r;
    spd_nxt        = spd_r;
    rend_nxt       = rend_r;
    mag_nxt        = mag_r;
    an_nxt         = an_r;
    ae_nxt         = ae_r;
    neg_n_nxt      = neg_n_r;
    neg_e_nxt      = neg_e_r;
    zero_nxt       = zero_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    len_nxt        = len_r;
    qn_nxt         = qn_r;
    qe_nxt         = qe_r;
    next_index_nxt = next_index_r;
    prev_n_nxt     = prev_n_r;
    prev_e_nxt     = prev_e_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    itr_ctrl.start = 1'b0;
    itr_ctrl.op    = wps_pkg::OP_DIV;
    itr_ctrl.a     = wps_pkg::CURV_NUM;
    itr_ctrl.b     = {1'b0, rad_r};

    unique case (state_r)
      wps_pkg::S_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_tuser;
          mode_nxt = in_tdata[2:0];
          cn_nxt   = in_tdata[34:3];
          ce_nxt   = in_tdata[66:35];
          cd_nxt   = in_tdata[98:67];
          rad_nxt  = in_tdata[129:99];
          spd_nxt  = in_tdata[160:130];
          rend_nxt = in_tlast;
          state_nxt = (in_tuser == wps_pkg::FUNC_START) ? wps_pkg::S_EMIT_B :
                      wps_pkg::S_CURV_GO;
        end
      end
      wps_pkg::S_CURV_GO: begin
        if (rad_r <= wps_pkg::CURV_SAT_R) begin
          mag_nxt   = wps_pkg::CURV_MAX;
          state_nxt = is_orbit ? wps_pkg::S_VEC : wps_pkg::S_EMIT_B;
        end else begin
          itr_ctrl.start = 1'b1;
          state_nxt      = wps_pkg::S_CURV_WT;
        end
      end
      wps_pkg::S_CURV_WT: begin
        if (itr_stat.done) begin
          mag_nxt   = itr_stat.result[30:0];
          state_nxt = is_orbit ? wps_pkg::S_VEC : wps_pkg::S_EMIT_B;
        end
      end
      wps_pkg::S_VEC: begin
        neg_n_nxt = dn[32];
        neg_e_nxt = de[32];
        if (abs_n[31] | abs_e[31]) begin
          an_nxt = abs_n[31:1];
          ae_nxt = abs_e[31:1];
        end else begin
          an_nxt = abs_n[30:0];
          ae_nxt = abs_e[30:0];
        end
        zero_nxt  = (abs_n == '0) && (abs_e == '0);
        state_nxt = wps_pkg::S_SQ_N;
      end
      wps_pkg::S_SQ_N: begin
        prod_nxt  = mul_p;
        state_nxt = zero_r ? wps_pkg::S_EMIT_A : wps_pkg::S_SQ_E;
      end
      wps_pkg::S_SQ_E: begin
        acc_nxt   = {1'b0, prod_r};
        prod_nxt  = mul_p;
        state_nxt = wps_pkg::S_SQ_ADD;
      end
      wps_pkg::S_SQ_ADD: begin
        acc_nxt   = acc_r + {1'b0, prod_r};
        state_nxt = wps_pkg::S_SQRT_GO;
      end
      wps_pkg::S_SQRT_GO: begin
        itr_ctrl.start = 1'b1;
        itr_ctrl.op    = wps_pkg::OP_SQRT;
        itr_ctrl.a     = {1'b0, acc_r};
        state_nxt      = wps_pkg::S_SQRT_WT;
      end
      wps_pkg::S_SQRT_WT: begin
        if (itr_stat.done) begin
          len_nxt   = itr_stat.result;
          state_nxt = wps_pkg::S_MUL_N;
        end
      end
      wps_pkg::S_MUL_N: begin
        prod_nxt  = mul_p;
        state_nxt = wps_pkg::S_DIVN_GO;
      end
      wps_pkg::S_DIVN_GO: begin
        itr_ctrl.start = 1'b1;
        itr_ctrl.a     = {2'b00, prod_r};
        itr_ctrl.b     = len_r;
        state_nxt      = wps_pkg::S_DIVN_WT;
      end
      wps_pkg::S_DIVN_WT: begin
        if (itr_stat.done) begin
          qn_nxt    = itr_stat.result[30:0];
          state_nxt = wps_pkg::S_MUL_E;
        end
      end
      wps_pkg::S_MUL_E: begin
        prod_nxt  = mul_p;
        state_nxt = wps_pkg::S_DIVE_GO;
      end
      wps_pkg::S_DIVE_GO: begin
        itr_ctrl.start = 1'b1;
        itr_ctrl.a     = {2'b00, prod_r};
        itr_ctrl.b     = len_r;
        state_nxt      = wps_pkg::S_DIVE_WT;
      end
      wps_pkg::S_DIVE_WT: begin
        if (itr_stat.done) begin
          qe_nxt    = itr_stat.result[30:0];
          state_nxt = wps_pkg::S_EMIT_A;
        end
      end
      wps_pkg::S_EMIT_A: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {1'b0, 32'd0, spd_r, cd_r, ee, en, 8'(idx)};
        out_user_nxt  = {1'b0, full, 1'b0};
        out_last_nxt  = 1'b0;
        next_index_nxt = full ? idx : idx + IW'(1);
        prev_n_nxt    = en;
        prev_e_nxt    = ee;
        state_nxt     = wps_pkg::S_HOLD_A;
      end
      wps_pkg::S_HOLD_A: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = wps_pkg::S_EMIT_B;
        end
      end
      wps_pkg::S_EMIT_B: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        next_index_nxt = full ? idx : idx + IW'(1);
        if (func_r == wps_pkg::FUNC_START) begin
          out_data_nxt = {1'b0, 32'd0, wps_pkg::START_SPEED, cd_r, ce_r, cn_r, 8'(idx)};
          out_user_nxt = {1'b0, full, 1'b0};
          prev_n_nxt   = cn_r;
          prev_e_nxt   = ce_r;
        end else if (is_orbit) begin
          out_data_nxt = {1'b0, curv, spd_r, cd_r, oe, on, 8'(idx)};
          out_user_nxt = {rend_r, full, 1'b1};
          prev_n_nxt   = on;
          prev_e_nxt   = oe;
        end else begin
          out_data_nxt = {1'b0, curv, spd_r, cd_r, ce_r, cn_r, 8'(idx)};
          out_user_nxt = {rend_r, full, 1'b0};
          prev_n_nxt   = cn_r;
          prev_e_nxt   = ce_r;
        end
        state_nxt = wps_pkg::S_HOLD_B;
      end
      wps_pkg::S_HOLD_B: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = wps_pkg::S_IDLE;
        end
      end
      default: state_nxt = wps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wps_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      next_index_r <= '0;
      prev_n_r     <= '0;
      prev_e_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      next_index_r <= next_index_nxt;
      prev_n_r     <= prev_n_nxt;
      prev_e_r     <= prev_e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    mode_r     <= mode_nxt;
    cn_r       <= cn_nxt;
    ce_r       <= ce_nxt;
    cd_r       <= cd_nxt;
    rad_r      <= rad_nxt;
    spd_r      <= spd_nxt;
    rend_r     <= rend_nxt;
    mag_r      <= mag_nxt;
    an_r       <= an_nxt;
    ae_r       <= ae_nxt;
    neg_n_r    <= neg_n_nxt;
    neg_e_r    <= neg_e_nxt;
    zero_r     <= zero_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    len_r      <= len_nxt;
    qn_r       <= qn_nxt;
    qe_r       <= qe_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `WPS_ASSERT_IMPL(a_idle_no_out, in_tready, !out_tvalid)
  `WPS_ASSERT_IMPL(a_index_bound, 1'b1, next_index_r <= IW'(MAX_SEGMENTS))
  `WPS_ASSERT_IMPL(a_orbit_last, out_tvalid && out_tuser[0], out_tlast)
  `WPS_ASSERT_NEXT(a_done_waited, itr_stat.done,
                   (state_r == wps_pkg::S_MUL_N) || (state_r == wps_pkg::S_MUL_E) ||
                   (state_r == wps_pkg::S_EMIT_A) || (state_r == wps_pkg::S_EMIT_B) ||
                   (state_r == wps_pkg::S_VEC))

endmodule

>>> rtl/core/wps_itr.sv
// Shared restoring divider / square root, one result bit per cycle.
// Divide: quotient must fit 31 bits (a >> 31 < b). Sqrt: 32 result bits.
module wps_itr (
  input  logic              clk,
  input  logic              rst_n,
  input  wps_pkg::itr_ctrl_t ctrl,
  output wps_pkg::itr_stat_t stat
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  wps_pkg::itr_op_t op_r, op_nxt;
  logic [31:0]      b_r, b_nxt;
  logic [63:0]      x_r, x_nxt;
  logic [33:0]      rem_r, rem_nxt;
  logic [31:0]      q_r, q_nxt;

  logic [35:0] cand, trial, diff;
  logic        ge;

  always_comb begin
    if (op_r == wps_pkg::OP_SQRT) begin
      cand  = {rem_r, x_r[63:62]};
      trial = {2'b00, q_r, 2'b01};
    end else begin
      cand  = {1'b0, rem_r, x_r[63]};
      trial = {4'b0000, b_r};
    end
    ge   = cand >= trial;
    diff = cand - trial;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    b_nxt    = b_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      b_nxt    = ctrl.b;
      q_nxt    = '0;
      if (ctrl.op == wps_pkg::OP_SQRT) begin
        rem_nxt = '0;
        x_nxt   = ctrl.a;
        cnt_nxt = 6'd32;
      end else begin
        rem_nxt = {1'b0, ctrl.a[63:31]};
        x_nxt   = {ctrl.a[30:0], 33'd0};
        cnt_nxt = 6'd31;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[33:0] : cand[33:0];
      q_nxt   = {q_r[30:0], ge};
      x_nxt   = (op_r == wps_pkg::OP_SQRT) ? {x_r[61:0], 2'b00} : {x_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.done   = done_r;
  assign stat.result = q_r;

endmodule

>>> tb/waypoint_to_path_segments_core_checker.sv
module waypoint_to_path_segments_core_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  localparam int unsigned TABLE_SIZE = wps_pkg::MAX_SEGMENTS_DEF;

  typedef struct packed {
    logic [2:0]  tuser;
    logic        tlast;
    logic [167:0] tdata;
  } descriptor_t;

  descriptor_t expected_descs[$];
  logic signed [31:0] last_north, last_east;
  int unsigned        seg_count;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic push_descriptor(logic [31:0] n, logic [31:0] e, logic [31:0] d,
                                 logic [30:0] spd, logic [31:0] curv, logic orbit,
                                 logic rdone, logic lst);
    descriptor_t x;
    logic full;
    full = seg_count >= TABLE_SIZE;
    x.tdata = {1'b0, curv, spd, d, e, n, seg_count[7:0]};
    x.tuser = {rdone, full, orbit};
    x.tlast = lst;
    expected_descs.push_back(x);
    if (!full) seg_count++;
    last_north = n;
    last_east = e;
  endtask

  task automatic predict_segments(logic func, logic [167:0] d, logic rend);
    logic [2:0]  mode;
    logic [31:0] pn, pe, pd, mag, curv;
    logic [30:0] rad, spd;
    logic        right, left;
    longint      cn, ce, dn, de, offn, offe;
    longint unsigned an, ae, q, len;
    mode = d[2:0];
    pn = d[34:3];
    pe = d[66:35];
    pd = d[98:67];
    rad = d[129:99];
    spd = d[160:130];
    if (func == wps_pkg::FUNC_START) begin
      seg_count = 0;
      push_descriptor(pn, pe, pd, wps_pkg::START_SPEED, 32'd0, 1'b0, 1'b0, 1'b1);
      return;
    end
    right = mode inside {wps_pkg::MODE_FLY_RIGHT, wps_pkg::MODE_DRIVE_RIGHT,
                         wps_pkg::MODE_ORBIT_RIGHT};
    left = mode inside {wps_pkg::MODE_FLY_LEFT, wps_pkg::MODE_DRIVE_LEFT,
                        wps_pkg::MODE_ORBIT_LEFT};
    if (rad == 0) mag = {1'b0, wps_pkg::CURV_MAX};
    else begin
      q = (64'd1 << 40) / rad;
      mag = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    curv = right ? mag : left ? -mag : 32'd0;
    if (mode != wps_pkg::MODE_ORBIT_RIGHT && mode != wps_pkg::MODE_ORBIT_LEFT) begin
      push_descriptor(pn, pe, pd, spd, curv, 1'b0, rend, 1'b1);
      return;
    end
    cn = longint'($signed(pn));
    ce = longint'($signed(pe));
    dn = cn - longint'(last_north);
    de = ce - longint'(last_east);
    an = dn < 0 ? -dn : dn;
    ae = de < 0 ? -de : de;
    while (an >= 64'h8000_0000 || ae >= 64'h8000_0000) begin
      an >>= 1;
      ae >>= 1;
    end
    if (an == 0 && ae == 0) begin
      offn = longint'(rad);
      offe = 0;
    end else begin
      len = int_sqrt(an * an + ae * ae);
      offn = (an * rad) / len;
      offe = (ae * rad) / len;
      if (dn < 0) offn = -offn;
      if (de < 0) offe = -offe;
    end
    push_descriptor(clamp32(cn - offn), clamp32(ce - offe), pd, spd, 32'd0,
                    1'b0, 1'b0, 1'b0);
    if (right)
      push_descriptor(clamp32(cn + offn), clamp32(ce - offe), pd, spd, curv,
                      1'b1, rend, 1'b1);
    else
      push_descriptor(clamp32(cn - offn), clamp32(ce + offe), pd, spd, curv,
                      1'b1, rend, 1'b1);
  endtask

  assign pending = expected_descs.size();

  always @(posedge clk) begin
    descriptor_t got, want;
    if (!rst_n) begin
      fail_count = 0;
      last_north = '0;
      last_east = '0;
      seg_count = 0;
      expected_descs.delete();
    end else begin
      // predict first, so each descriptor is queued before it can come out
      if (in_tvalid && in_tready) predict_segments(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.tdata = out_tdata;
        got.tuser = out_tuser;
        got.tlast = out_tlast;
        if (expected_descs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected descriptor %h", got);
        end else begin
          want = expected_descs.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("descriptor mismatch: expected %h actual %h", want, got);
          end
        end
      end
    end
  end
endmodule

>>> tb/waypoint_to_path_segments_core_tb.sv
module waypoint_to_path_segments_core_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready, in_tuser, in_tlast;
  logic [167:0] in_tdata;
  logic         out_tvalid, out_tready, out_tlast;
  logic [167:0] out_tdata;
  logic [2:0]   out_tuser;
  int           fail_count, pending;
  int           send_idle_pct, recv_stall_pct;
  bit           hold_off;

  waypoint_to_path_segments_core i_dut (.*);
  waypoint_to_path_segments_core_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #80_000_000;
    $display("waypoint_to_path_segments_core_tb failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_len();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1, 600));
      default: return 31'($urandom);
    endcase
  endfunction

  // valid stays up after a transaction until the next item or an idle cycle
  task automatic send_item(logic func, logic [2:0] mode, logic [31:0] n, logic [31:0] e,
                           logic [31:0] d, logic [30:0] rad, logic [30:0] spd,
                           logic rend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tlast <= rend;
    in_tdata <= {7'd0, spd, rad, d, e, n, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [2:0] mode;
    mode = 3'($urandom_range(7));
    // starts are rare so routes get long enough to fill the table at times
    send_item($urandom_range(40) != 0, mode, rand_coord(), rand_coord(), rand_coord(),
              rand_len(), rand_len(), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle = '{0, 49, 0, 11};
    phase_stall = '{0, 0, 49, 11};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    in_tdata = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // waypoint before any start, then a start and the orbit corner cases
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_ORBIT_RIGHT, 0, 0, 0, 31'd65536,
              31'd100, 1'b0);
    send_item(wps_pkg::FUNC_START, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    for (int m = 0; m < 8; m++)
      send_item(wps_pkg::FUNC_WAYPOINT, 3'(m), $urandom, $urandom, $urandom, rand_len(),
                rand_len(), m[0]);
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_STRAIGHT, 0, 0, 0, 31'd0, 31'd0, 1'b0);
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_FLY_LEFT, 0, 0, 0, 31'd512, 31'd5, 1'b0);
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_DRIVE_RIGHT, 0, 0, 0, 31'd513, 31'd5,
              1'b0);
    // zero approach vector: centre equals previous locus
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_ORBIT_LEFT, 0, 0, 7, 31'd1000, 31'd5,
              1'b1);
    // saturating orbit at the coordinate extremes
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_ORBIT_RIGHT, 32'h7FFF_FFFF,
              32'h8000_0000, 0, 31'h7FFF_FFFF, 31'd1, 1'b0);
    send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_ORBIT_LEFT, 32'h8000_0000,
              32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 31'd1, 1'b1);
    // full table
    send_item(wps_pkg::FUNC_START, wps_pkg::MODE_STRAIGHT, 0, 0, 0, 31'd0, 31'd0, 1'b0);
    for (int i = 0; i < 258; i++) begin
      send_idle_pct = 0;
      send_item(wps_pkg::FUNC_WAYPOINT, wps_pkg::MODE_STRAIGHT, i, -i, 0, 31'd1, 31'd2,
                i == 257);
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 185; i++) begin
        if (p == 2 && i == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (2000) @(negedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_random();
      end
    end
    drain();

    if (fail_count == 0 && pending == 0)
      $display("waypoint_to_path_segments_core_tb passed");
    else
      $display("waypoint_to_path_segments_core_tb failed");
    $finish;
  end
endmodule
